FILE: rtl/core/pcf_pkg.sv
package pcf_pkg;

   localparam int PosWidth   = 15;
   localparam int ForceWidth = 24;
   localparam int GainWidth  = 16;
   localparam int IndexWidth = 6;

   localparam logic [GainWidth-1:0]  GainReset = 16'd1000;
   localparam logic [15:0]           MinDist   = 16'd16;
   localparam logic [ForceWidth-1:0] ForceMax  = 24'h7FFFFF;
   localparam logic [ForceWidth-1:0] ForceMin  = 24'h800000;

   typedef struct packed {
      logic [PosWidth-1:0] x;
      logic [PosWidth-1:0] y;
      logic                neg;
   } particle_type;

   typedef struct packed {
      particle_type          part;
      logic [ForceWidth-1:0] fx;
      logic [ForceWidth-1:0] fy;
   } cell_type;

   typedef struct packed {
      logic                  done;
      logic [ForceWidth-1:0] fx;
      logic [ForceWidth-1:0] fy;
   } pair_result_type;

   typedef enum logic [1:0] {
      T_LOAD,
      T_STEP,
      T_WAIT,
      T_EMIT
   } core_state_type;

   typedef enum logic [3:0] {
      P_IDLE,
      P_SQUARE,
      P_SUM,
      P_SQRT,
      P_DQ2,
      P_CUBE,
      P_CHECK,
      P_DIV,
      P_DONE
   } pair_state_type;

   function automatic logic [ForceWidth-1:0] sat_add(logic [ForceWidth-1:0] a,
                                                     logic [ForceWidth-1:0] b);
      logic [ForceWidth:0] s;
      s = {a[ForceWidth-1], a} + {b[ForceWidth-1], b};
      if (s[ForceWidth] != s[ForceWidth-1]) begin
         return s[ForceWidth] ? ForceMin : ForceMax;
      end
      return s[ForceWidth-1:0];
   endfunction

   function automatic logic [ForceWidth-1:0] sat_sub(logic [ForceWidth-1:0] a,
                                                     logic [ForceWidth-1:0] b);
      logic [ForceWidth:0] s;
      s = {a[ForceWidth-1], a} - {b[ForceWidth-1], b};
      if (s[ForceWidth] != s[ForceWidth-1]) begin
         return s[ForceWidth] ? ForceMin : ForceMax;
      end
      return s[ForceWidth-1:0];
   endfunction

endpackage

FILE: rtl/core/pcf_cell.sv
module pcf_cell (
   input  logic                   clock,
   input  logic                   load_en,
   input  pcf_pkg::particle_type  load_part,
   input  logic                   shift_en,
   input  pcf_pkg::cell_type      shift_in,
   output pcf_pkg::cell_type      cell_out
);

   pcf_pkg::cell_type data_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         data_ff <= '{part: load_part, fx: '0, fy: '0};
      end else if (shift_en) begin
         data_ff <= shift_in;
      end
   end

   assign cell_out = data_ff;

endmodule

FILE: rtl/core/pcf_pair.sv
module pcf_pair (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  pcf_pkg::particle_type    pivot,
   input  pcf_pkg::particle_type    head,
   input  logic [15:0]              gain,
   output pcf_pkg::pair_result_type result
);

   pcf_pkg::pair_state_type state_ff, state_in;

   logic [14:0] magx_ff, magy_ff;
   logic        negx_ff, negy_ff;
   logic [29:0] sqx_ff, sqy_ff;
   logic [31:0] val_ff;
   logic [16:0] rem_ff;
   logic [15:0] root_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] dq2_ff;
   logic [46:0] cube_ff;
   logic [30:0] numx_ff, numy_ff;
   logic        bigx_ff, bigy_ff;
   logic [46:0] remx_ff, remy_ff;
   logic [22:0] lowx_ff, lowy_ff;
   logic [22:0] qx_ff, qy_ff;

   logic [15:0] diffx, diffy;
   logic [18:0] sq_trial, sq_rem;
   logic [15:0] dq;
   logic [46:0] numx_w, numy_w;
   logic [47:0] divx_t, divy_t, cube_x;

   always_comb begin
      diffx    = {1'b0, head.x} - {1'b0, pivot.x};
      diffy    = {1'b0, head.y} - {1'b0, pivot.y};
      sq_rem   = {rem_ff, val_ff[31:30]};
      sq_trial = {1'b0, root_ff, 2'b01};
      dq       = (root_ff < pcf_pkg::MinDist) ? pcf_pkg::MinDist : root_ff;
      numx_w   = {numx_ff, 16'b0};
      numy_w   = {numy_ff, 16'b0};
      divx_t   = {remx_ff, lowx_ff[22]};
      divy_t   = {remy_ff, lowy_ff[22]};
      cube_x   = {1'b0, cube_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcf_pkg::P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      result   = '{done: 1'b0, fx: '0, fy: '0};
      unique case (state_ff)
         pcf_pkg::P_IDLE:   if (start) state_in = pcf_pkg::P_SQUARE;
         pcf_pkg::P_SQUARE: state_in = pcf_pkg::P_SUM;
         pcf_pkg::P_SUM:    state_in = pcf_pkg::P_SQRT;
         pcf_pkg::P_SQRT:   if (cnt_ff == 5'd15) state_in = pcf_pkg::P_DQ2;
         pcf_pkg::P_DQ2:    state_in = pcf_pkg::P_CUBE;
         pcf_pkg::P_CUBE:   state_in = pcf_pkg::P_CHECK;
         pcf_pkg::P_CHECK:  state_in = pcf_pkg::P_DIV;
         pcf_pkg::P_DIV:    if (cnt_ff == 5'd22) state_in = pcf_pkg::P_DONE;
         pcf_pkg::P_DONE: begin
            state_in    = pcf_pkg::P_IDLE;
            result.done = 1'b1;
            if (bigx_ff) begin
               result.fx = negx_ff ? pcf_pkg::ForceMin : pcf_pkg::ForceMax;
            end else begin
               result.fx = negx_ff ? 24'(-{1'b0, qx_ff}) : {1'b0, qx_ff};
            end
            if (bigy_ff) begin
               result.fy = negy_ff ? pcf_pkg::ForceMin : pcf_pkg::ForceMax;
            end else begin
               result.fy = negy_ff ? 24'(-{1'b0, qy_ff}) : {1'b0, qy_ff};
            end
         end
         default: state_in = pcf_pkg::P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         pcf_pkg::P_IDLE: begin
            magx_ff <= diffx[15] ? 15'(-diffx) : diffx[14:0];
            magy_ff <= diffy[15] ? 15'(-diffy) : diffy[14:0];
            negx_ff <= diffx[15] ^ pivot.neg ^ head.neg;
            negy_ff <= diffy[15] ^ pivot.neg ^ head.neg;
         end
         pcf_pkg::P_SQUARE: begin
            sqx_ff <= magx_ff * magx_ff;
            sqy_ff <= magy_ff * magy_ff;
         end
         pcf_pkg::P_SUM: begin
            val_ff  <= {1'b0, {1'b0, sqx_ff} + {1'b0, sqy_ff}};
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         pcf_pkg::P_SQRT: begin
            val_ff <= {val_ff[29:0], 2'b00};
            cnt_ff <= cnt_ff + 5'd1;
            if (sq_rem >= sq_trial) begin
               rem_ff  <= 17'(sq_rem - sq_trial);
               root_ff <= {root_ff[14:0], 1'b1};
            end else begin
               rem_ff  <= sq_rem[16:0];
               root_ff <= {root_ff[14:0], 1'b0};
            end
         end
         pcf_pkg::P_DQ2: begin
            root_ff <= dq;
            dq2_ff  <= dq * dq;
         end
         pcf_pkg::P_CUBE: begin
            cube_ff <= 47'({16'b0, dq2_ff} * {32'b0, root_ff});
            numx_ff <= gain * magx_ff;
            numy_ff <= gain * magy_ff;
         end
         pcf_pkg::P_CHECK: begin
            bigx_ff <= {23'b0, numx_w} >= {cube_ff, 23'b0};
            bigy_ff <= {23'b0, numy_w} >= {cube_ff, 23'b0};
            remx_ff <= {23'b0, numx_w[46:23]};
            remy_ff <= {23'b0, numy_w[46:23]};
            lowx_ff <= numx_w[22:0];
            lowy_ff <= numy_w[22:0];
            qx_ff   <= '0;
            qy_ff   <= '0;
            cnt_ff  <= '0;
         end
         pcf_pkg::P_DIV: begin
            cnt_ff  <= cnt_ff + 5'd1;
            lowx_ff <= {lowx_ff[21:0], 1'b0};
            lowy_ff <= {lowy_ff[21:0], 1'b0};
            if (divx_t >= cube_x) begin
               remx_ff <= 47'(divx_t - cube_x);
               qx_ff   <= {qx_ff[21:0], 1'b1};
            end else begin
               remx_ff <= divx_t[46:0];
               qx_ff   <= {qx_ff[21:0], 1'b0};
            end
            if (divy_t >= cube_x) begin
               remy_ff <= 47'(divy_t - cube_x);
               qy_ff   <= {qy_ff[21:0], 1'b1};
            end else begin
               remy_ff <= divy_t[46:0];
               qy_ff   <= {qy_ff[21:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/pairwise_coulomb_force_core.sv
// Pairwise 2D Coulomb force core. Particles arrive one per transfer into a
// ring of particle cells; the transfer with tlast starts a run over the held particles
// (at most MAX_PARTICLES, extra ones are dropped). A run makes n passes of n+1 ring steps,
// and each of the n*(n-1)/2 pairs holds its step while the shared pair unit runs it
// (square root, then division); when the run is done, one result per particle leaves
// in load order. No input is taken from the first tlast until the last result.
module pairwise_coulomb_force_core #(
   parameter int MAX_PARTICLES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // pos_x[14:0], pos_y[29:15], charge_negative[30]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // particle_index[5:0], force_x[29:6], force_y[53:30]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(MAX_PARTICLES + 1);

   pcf_pkg::core_state_type  state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            num_ff, num_in;
   logic [CW-1:0]            pass_ff, pass_in;
   logic [CW-1:0]            step_ff, step_in;
   logic [CW-1:0]            emit_ff, emit_in;
   logic [15:0]              gain_ff;
   pcf_pkg::cell_type        pivot_ff, pivot_in;

   pcf_pkg::cell_type        cells [MAX_PARTICLES];
   pcf_pkg::cell_type        head, ring_in;
   pcf_pkg::particle_type    load_part;
   pcf_pkg::pair_result_type pair_res;
   logic                     rotate, load_en, pair_start;

   assign head      = cells[0];
   assign load_part = '{x: req_tdata[14:0], y: req_tdata[29:15], neg: req_tdata[30]};
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= pcf_pkg::GainReset;
      end else if (csr_valid) begin
         gain_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcf_pkg::T_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      pass_ff  <= pass_in;
      step_ff  <= step_in;
      emit_ff  <= emit_in;
      pivot_ff <= pivot_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      num_in     = num_ff;
      pass_in    = pass_ff;
      step_in    = step_ff;
      emit_in    = emit_ff;
      pivot_in   = pivot_ff;
      ring_in    = head;
      rotate     = 1'b0;
      load_en    = 1'b0;
      pair_start = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         pcf_pkg::T_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (count_ff < CW'(MAX_PARTICLES)) begin
                  load_en  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_tlast) begin
                  num_in   = (count_ff < CW'(MAX_PARTICLES)) ? count_ff + 1'b1 : count_ff;
                  count_in = '0;
                  pass_in  = '0;
                  step_in  = '0;
                  state_in = pcf_pkg::T_STEP;
               end
            end
         end
         pcf_pkg::T_STEP: begin
            if (step_ff == '0) begin
               pivot_in = head;
               rotate   = 1'b1;
               step_in  = step_ff + 1'b1;
            end else if (step_ff == num_ff) begin
               ring_in.fx = pivot_ff.fx;
               ring_in.fy = pivot_ff.fy;
               rotate     = 1'b1;
               step_in    = '0;
               if (pass_ff == num_ff - 1'b1) begin
                  emit_in  = '0;
                  state_in = pcf_pkg::T_EMIT;
               end else begin
                  pass_in = pass_ff + 1'b1;
               end
            end else if ({1'b0, pass_ff} + {1'b0, step_ff} < {1'b0, num_ff}) begin
               pair_start = 1'b1;
               state_in   = pcf_pkg::T_WAIT;
            end else begin
               rotate  = 1'b1;
               step_in = step_ff + 1'b1;
            end
         end
         pcf_pkg::T_WAIT: begin
            if (pair_res.done) begin
               ring_in.fx  = pcf_pkg::sat_add(head.fx, pair_res.fx);
               ring_in.fy  = pcf_pkg::sat_add(head.fy, pair_res.fy);
               pivot_in.fx = pcf_pkg::sat_sub(pivot_ff.fx, pair_res.fx);
               pivot_in.fy = pcf_pkg::sat_sub(pivot_ff.fy, pair_res.fy);
               rotate      = 1'b1;
               step_in     = step_ff + 1'b1;
               state_in    = pcf_pkg::T_STEP;
            end
         end
         pcf_pkg::T_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               rotate  = 1'b1;
               emit_in = emit_ff + 1'b1;
               if (emit_ff == num_ff - 1'b1) begin
                  state_in = pcf_pkg::T_LOAD;
               end
            end
         end
         default: state_in = pcf_pkg::T_LOAD;
      endcase
   end

   assign rsp_tdata = {2'b00, head.fy, head.fx, 6'(emit_ff)};
   assign rsp_tlast = (emit_ff == num_ff - 1'b1);

   for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_cell
      pcf_pkg::cell_type next_cell;
      if (k == MAX_PARTICLES - 1) begin : g_tail
         assign next_cell = ring_in;
      end else begin : g_mid
         assign next_cell = (CW'(k) == num_ff - 1'b1) ? ring_in : cells[k+1];
      end
      pcf_cell u_cell (
         .clock     (clock),
         .load_en   (load_en && (count_ff == CW'(k))),
         .load_part (load_part),
         .shift_en  (rotate && (CW'(k) < num_ff)),
         .shift_in  (next_cell),
         .cell_out  (cells[k])
      );
   end

   pcf_pair u_pair (
      .clock  (clock),
      .reset  (reset),
      .start  (pair_start),
      .pivot  (pivot_ff.part),
      .head   (head.part),
      .gain   (gain_ff),
      .result (pair_res)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result channels active together");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PARTICLES))
      else $error("load count beyond store depth");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("no return to loading after last result");

endmodule
